// ----- rtl/core/mips_ex_pkg.sv -----
// ----------------------------------------------------------------------------
// mips_ex_pkg
// Shared types and codes of the MIPS execute stage: ALU op codes, R-type
// funct codes, the decoded ALU function and the ALU result bundle.
// ----------------------------------------------------------------------------
package mips_ex_pkg;

	localparam int unsigned XLEN     = 32;
	localparam int unsigned REG_IDXW = 5;
	localparam int unsigned OPW      = 3;
	localparam int unsigned FUNCTW   = 6;
	localparam int unsigned SHAMTW   = 5;
	localparam int unsigned SHAMT_LSB = 6;

	// Redirect target fetch must jump to when an overflow trap is taken.
	localparam logic [XLEN-1:0] TRAP_VECTOR = 32'h0000_8000;

	// ALU op codes from decode.
	localparam logic [OPW-1:0] OP_ADD   = 3'd0;
	localparam logic [OPW-1:0] OP_AND   = 3'd1;
	localparam logic [OPW-1:0] OP_SUB   = 3'd2;
	localparam logic [OPW-1:0] OP_OR    = 3'd3;
	localparam logic [OPW-1:0] OP_RTYPE = 3'd4;
	localparam logic [OPW-1:0] OP_SLT   = 3'd5;
	localparam logic [OPW-1:0] OP_LUI   = 3'd7;

	// R-type funct codes.
	localparam logic [FUNCTW-1:0] FN_SLL  = 6'h00;
	localparam logic [FUNCTW-1:0] FN_SRL  = 6'h02;
	localparam logic [FUNCTW-1:0] FN_ADD  = 6'h20;
	localparam logic [FUNCTW-1:0] FN_ADDU = 6'h21;
	localparam logic [FUNCTW-1:0] FN_SUB  = 6'h22;
	localparam logic [FUNCTW-1:0] FN_SUBU = 6'h23;
	localparam logic [FUNCTW-1:0] FN_AND  = 6'h24;
	localparam logic [FUNCTW-1:0] FN_OR   = 6'h25;
	localparam logic [FUNCTW-1:0] FN_NOR  = 6'h27;
	localparam logic [FUNCTW-1:0] FN_SLT  = 6'h2a;
	localparam logic [FUNCTW-1:0] FN_SLTU = 6'h2b;

	typedef enum logic [3:0] {
		ALU_AND,
		ALU_OR,
		ALU_ADD,
		ALU_SUB,
		ALU_SLT,
		ALU_SLL,
		ALU_SRL,
		ALU_NOR,
		ALU_LUI
	} alu_fn_t;

	typedef struct packed {
		logic [XLEN-1:0] result;
		logic            overflow;
	} alu_out_t;

endpackage

// ----- rtl/core/mips_ex_alu.sv -----
// ----------------------------------------------------------------------------
// mips_ex_alu
// Decodes the ALU op and funct and computes one result with its trapped
// signed-overflow flag. Purely combinational.
// ----------------------------------------------------------------------------
module mips_ex_alu (
	input  logic [mips_ex_pkg::OPW-1:0]  alu_op,
	input  logic                         trap_on_overflow,
	input  logic [mips_ex_pkg::XLEN-1:0] operand_a,
	input  logic [mips_ex_pkg::XLEN-1:0] operand_b,
	input  logic [mips_ex_pkg::XLEN-1:0] immediate,
	output mips_ex_pkg::alu_out_t        alu_out
);

	mips_ex_pkg::alu_fn_t                fn;
	logic [mips_ex_pkg::FUNCTW-1:0]      funct;
	logic [mips_ex_pkg::SHAMTW-1:0]      shamt;
	logic [mips_ex_pkg::XLEN-1:0]        sum;
	logic [mips_ex_pkg::XLEN-1:0]        diff;
	logic                                sign_a;
	logic                                sign_b;
	logic                                less;

	assign funct  = immediate[mips_ex_pkg::FUNCTW-1:0];
	assign shamt  = immediate[mips_ex_pkg::SHAMT_LSB +: mips_ex_pkg::SHAMTW];
	assign sign_a = operand_a[mips_ex_pkg::XLEN-1];
	assign sign_b = operand_b[mips_ex_pkg::XLEN-1];
	assign sum    = operand_a + operand_b;
	assign diff   = operand_a - operand_b;

	// With the trap enabled, slt and sltu both compare as signed numbers.
	assign less = trap_on_overflow ? ($signed(operand_a) < $signed(operand_b))
	                               : (operand_a < operand_b);

	always_comb begin
		unique case (alu_op)
			mips_ex_pkg::OP_ADD: fn = mips_ex_pkg::ALU_ADD;
			mips_ex_pkg::OP_AND: fn = mips_ex_pkg::ALU_AND;
			mips_ex_pkg::OP_SUB: fn = mips_ex_pkg::ALU_SUB;
			mips_ex_pkg::OP_OR:  fn = mips_ex_pkg::ALU_OR;
			mips_ex_pkg::OP_SLT: fn = mips_ex_pkg::ALU_SLT;
			mips_ex_pkg::OP_LUI: fn = mips_ex_pkg::ALU_LUI;
			mips_ex_pkg::OP_RTYPE: begin
				unique case (funct) inside
					mips_ex_pkg::FN_ADD, mips_ex_pkg::FN_ADDU: fn = mips_ex_pkg::ALU_ADD;
					mips_ex_pkg::FN_SUB, mips_ex_pkg::FN_SUBU: fn = mips_ex_pkg::ALU_SUB;
					mips_ex_pkg::FN_AND:                       fn = mips_ex_pkg::ALU_AND;
					mips_ex_pkg::FN_OR:                        fn = mips_ex_pkg::ALU_OR;
					mips_ex_pkg::FN_NOR:                       fn = mips_ex_pkg::ALU_NOR;
					mips_ex_pkg::FN_SLT, mips_ex_pkg::FN_SLTU: fn = mips_ex_pkg::ALU_SLT;
					mips_ex_pkg::FN_SLL:                       fn = mips_ex_pkg::ALU_SLL;
					mips_ex_pkg::FN_SRL:                       fn = mips_ex_pkg::ALU_SRL;
					// Unknown functs, jr among them, fall back to AND.
					default:                                   fn = mips_ex_pkg::ALU_AND;
				endcase
			end
			default: fn = mips_ex_pkg::ALU_AND;
		endcase
	end

	always_comb begin
		alu_out.overflow = 1'b0;
		case (fn)
			mips_ex_pkg::ALU_OR:  alu_out.result = operand_a | operand_b;
			mips_ex_pkg::ALU_NOR: alu_out.result = ~(operand_a | operand_b);
			mips_ex_pkg::ALU_ADD: begin
				alu_out.result   = sum;
				alu_out.overflow = trap_on_overflow && (sign_a == sign_b)
				                   && (sign_b != sum[mips_ex_pkg::XLEN-1]);
			end
			mips_ex_pkg::ALU_SUB: begin
				alu_out.result   = diff;
				alu_out.overflow = trap_on_overflow && (sign_a != sign_b)
				                   && (sign_b == diff[mips_ex_pkg::XLEN-1]);
			end
			mips_ex_pkg::ALU_SLT: alu_out.result = {{(mips_ex_pkg::XLEN-1){1'b0}}, less};
			mips_ex_pkg::ALU_SLL: alu_out.result = operand_a << shamt;
			mips_ex_pkg::ALU_SRL: alu_out.result = operand_a >> shamt;
			mips_ex_pkg::ALU_LUI: alu_out.result = operand_b << 16;
			default:              alu_out.result = operand_a & operand_b;
		endcase
	end

endmodule

// ----- rtl/core/mips_execute_stage_with_forwarding.sv -----
// ----------------------------------------------------------------------------
// mips_execute_stage_with_forwarding
// Execute stage of a five-stage MIPS pipeline with operand forwarding.
// ----------------------------------------------------------------------------
// One decoded instruction enters as a request on the in_valid/in_ready
// channel and leaves as one result request on out_valid/out_ready.
// The request is captured in an input register; forwarding, the ALU and the
// overflow check then run combinationally into the output register, which
// drives out_valid and the result, and the stage takes one request every cycle
// as the receiver keeps up.
// Both source operands are forwarded: this stage's own previous result wins
// over the writeback value, and register zero is never forwarded. The
// forwarding copy of the previous result is updated when an instruction moves
// into the output register, so back-to-back dependent instructions see it.
// A trapped signed overflow clears the result, the destination and the write
// enable and raises overflow_trap; fetch then redirects to 0x8000.
// When the receiver stalls, the output register holds and the input register
// keeps one more request, after which in_ready drops. Reset empties both
// registers and clears the forwarding copy.
// ----------------------------------------------------------------------------
module mips_execute_stage_with_forwarding (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [mips_ex_pkg::OPW-1:0]      alu_op,
	input  logic                             use_immediate,
	input  logic                             trap_on_overflow,
	input  logic [mips_ex_pkg::XLEN-1:0]     rs_value,
	input  logic [mips_ex_pkg::XLEN-1:0]     rt_value,
	input  logic [mips_ex_pkg::XLEN-1:0]     immediate,
	input  logic [mips_ex_pkg::REG_IDXW-1:0] rs_index,
	input  logic [mips_ex_pkg::REG_IDXW-1:0] dest_index,
	input  logic                             write_enable,
	input  logic                             wb_write_enable,
	input  logic [mips_ex_pkg::REG_IDXW-1:0] wb_dest,
	input  logic [mips_ex_pkg::XLEN-1:0]     wb_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [mips_ex_pkg::XLEN-1:0]     alu_result,
	output logic                             zero_flag,
	output logic                             overflow_trap,
	output logic [mips_ex_pkg::XLEN-1:0]     store_data,
	output logic [mips_ex_pkg::REG_IDXW-1:0] dest_out,
	output logic                             write_enable_out
);

	// Input register
	logic                             valid_s1;
	logic [mips_ex_pkg::OPW-1:0]      alu_op_s1;
	logic                             use_imm_s1;
	logic                             trap_en_s1;
	logic [mips_ex_pkg::XLEN-1:0]     rs_value_s1;
	logic [mips_ex_pkg::XLEN-1:0]     rt_value_s1;
	logic [mips_ex_pkg::XLEN-1:0]     imm_s1;
	logic [mips_ex_pkg::REG_IDXW-1:0] rs_index_s1;
	logic [mips_ex_pkg::REG_IDXW-1:0] dest_s1;
	logic                             we_s1;
	logic                             wb_we_s1;
	logic [mips_ex_pkg::REG_IDXW-1:0] wb_dest_s1;
	logic [mips_ex_pkg::XLEN-1:0]     wb_value_s1;

	// Forwarding copy of the last executed instruction
	logic [mips_ex_pkg::XLEN-1:0]     prev_result_q;
	logic [mips_ex_pkg::REG_IDXW-1:0] prev_dest_q;
	logic                             prev_we_q;

	// Output register
	logic                             valid_q;
	logic [mips_ex_pkg::XLEN-1:0]     result_q;
	logic                             zero_q;
	logic                             trap_q;
	logic [mips_ex_pkg::XLEN-1:0]     store_q;
	logic [mips_ex_pkg::REG_IDXW-1:0] dest_q;
	logic                             we_q;

	logic                             advance;
	logic [mips_ex_pkg::XLEN-1:0]     fwd_a;
	logic [mips_ex_pkg::XLEN-1:0]     fwd_rt;
	logic [mips_ex_pkg::XLEN-1:0]     operand_b;
	mips_ex_pkg::alu_out_t            alu_out;
	logic [mips_ex_pkg::XLEN-1:0]     ex_result;
	logic                             ex_zero;
	logic [mips_ex_pkg::REG_IDXW-1:0] ex_dest;
	logic                             ex_we;

	assign advance  = valid_s1 && (!valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		fwd_a = rs_value_s1;
		if (rs_index_s1 != '0) begin
			if (prev_we_q && (prev_dest_q == rs_index_s1))
				fwd_a = prev_result_q;
			else if (wb_we_s1 && (wb_dest_s1 == rs_index_s1))
				fwd_a = wb_value_s1;
		end
	end

	// The second operand is looked up by the destination number.
	always_comb begin
		fwd_rt = rt_value_s1;
		if (dest_s1 != '0) begin
			if (prev_we_q && (prev_dest_q == dest_s1))
				fwd_rt = prev_result_q;
			else if (wb_we_s1 && (wb_dest_s1 == dest_s1))
				fwd_rt = wb_value_s1;
		end
	end

	assign operand_b = use_imm_s1 ? imm_s1 : fwd_rt;

	mips_ex_alu u_alu (
		.alu_op           (alu_op_s1),
		.trap_on_overflow (trap_en_s1),
		.operand_a        (fwd_a),
		.operand_b        (operand_b),
		.immediate        (imm_s1),
		.alu_out          (alu_out)
	);

	assign ex_result = alu_out.overflow ? '0 : alu_out.result;
	assign ex_zero   = !alu_out.overflow && (alu_out.result == '0);
	assign ex_dest   = alu_out.overflow ? '0 : dest_s1;
	assign ex_we     = !alu_out.overflow && we_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_q       <= 1'b0;
			prev_result_q <= '0;
			prev_dest_q   <= '0;
			prev_we_q     <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				valid_q <= 1'b1;
			else if (out_ready)
				valid_q <= 1'b0;
			if (advance) begin
				prev_result_q <= ex_result;
				prev_dest_q   <= ex_dest;
				prev_we_q     <= ex_we;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			alu_op_s1   <= alu_op;
			use_imm_s1  <= use_immediate;
			trap_en_s1  <= trap_on_overflow;
			rs_value_s1 <= rs_value;
			rt_value_s1 <= rt_value;
			imm_s1      <= immediate;
			rs_index_s1 <= rs_index;
			dest_s1     <= dest_index;
			we_s1       <= write_enable;
			wb_we_s1    <= wb_write_enable;
			wb_dest_s1  <= wb_dest;
			wb_value_s1 <= wb_value;
		end
		if (advance) begin
			result_q <= ex_result;
			zero_q   <= ex_zero;
			trap_q   <= alu_out.overflow;
			store_q  <= fwd_rt;
			dest_q   <= ex_dest;
			we_q     <= ex_we;
		end
	end

	assign out_valid        = valid_q;
	assign alu_result       = result_q;
	assign zero_flag        = zero_q;
	assign overflow_trap    = trap_q;
	assign store_data       = store_q;
	assign dest_out         = dest_q;
	assign write_enable_out = we_q;

	// A trapped instruction must not write anything.
	a_trap_cancels_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflow_trap) |->
		(!write_enable_out && (dest_out == '0) && (alu_result == '0) && !zero_flag))
		else $error("trapped result still carries a register write");

	a_zero_flag_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !overflow_trap) |-> (zero_flag == (alu_result == '0)))
		else $error("zero flag disagrees with result");

	// The forwarding copy always mirrors the instruction just executed.
	a_fwd_copy_tracks_output: assert property (@(posedge clk) disable iff (!arst_n)
		$past(advance) |->
		((prev_result_q == alu_result) && (prev_dest_q == dest_out)
		 && (prev_we_q == write_enable_out)))
		else $error("forwarding copy out of step with output register");

	a_empty_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("empty input register refuses a request");

endmodule
